### hw/rtl/backslash_escape_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the backslash escape decoder
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_DEFINES_SVH
`define BACKSLASH_ESCAPE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define BED_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition must never be seen at a clock edge out of reset
`define BED_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define BED_ASSERT(lbl, clk, rst_n, prop)
`define BED_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### hw/rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Types, character codes and helpers for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

    typedef logic [7:0] byte_t;

    // most decoded bytes one input item can release
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);

    // scan phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_HEX  = 3'd2,
        PH_R1   = 3'd3,
        PH_R2   = 3'd4,
        PH_R3   = 3'd5
    } phase_t;

    // decoder state carried from item to item
    typedef struct packed {
        phase_t      phase;
        logic [15:0] hex_accum;
        logic [2:0]  digit_count;
        logic        long_hex;
        logic [2:0]  first_octal;
    } scan_state_t;

    // burst of results released by one item
    typedef struct packed {
        byte_t [MAX_RESULTS-1:0] data;
        logic  [MAX_RESULTS-1:0] last;
        logic  [CNT_W-1:0]       count;
    } burst_t;

    // character codes
    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_ZERO   = 8'h30;
    localparam byte_t CH_SEVEN  = 8'h37;
    localparam byte_t CH_NINE   = 8'h39;
    localparam byte_t CH_UA     = 8'h41;
    localparam byte_t CH_UF     = 8'h46;
    localparam byte_t CH_LA     = 8'h61;
    localparam byte_t CH_LB     = 8'h62;
    localparam byte_t CH_LF     = 8'h66;
    localparam byte_t CH_LN     = 8'h6E;
    localparam byte_t CH_LR     = 8'h72;
    localparam byte_t CH_LT     = 8'h74;
    localparam byte_t CH_LU     = 8'h75;
    localparam byte_t CH_LV     = 8'h76;
    localparam byte_t CH_LX     = 8'h78;

    // control codes
    localparam byte_t CC_BEL = 8'd7;
    localparam byte_t CC_BS  = 8'd8;
    localparam byte_t CC_HT  = 8'd9;
    localparam byte_t CC_LF  = 8'd10;
    localparam byte_t CC_VT  = 8'd11;
    localparam byte_t CC_FF  = 8'd12;
    localparam byte_t CC_CR  = 8'd13;

    // digit limits for \x and \u
    localparam logic [2:0] HEX_SHORT_DIGITS = 3'd2;
    localparam logic [2:0] HEX_LONG_DIGITS  = 3'd4;

    // hex digit value: bit 4 = valid, bits 3:0 = value
    function automatic logic [4:0] hex_value(byte_t c);
        byte_t t;
        t = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
            return {1'b1, t[3:0]};
        end
        if (c >= CH_UA && c <= CH_UF) begin
            t = c - (CH_UA - 8'd10);
            return {1'b1, t[3:0]};
        end
        if (c >= CH_LA && c <= CH_LF) begin
            t = c - (CH_LA - 8'd10);
            return {1'b1, t[3:0]};
        end
        return 5'b0_0000;
    endfunction

    function automatic logic is_octal(byte_t c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // append one result to a burst
    function automatic burst_t push(burst_t b, byte_t v, logic lst);
        burst_t r;
        r = b;
        r.data[b.count[IDX_W-1:0]] = v;
        r.last[b.count[IDX_W-1:0]] = lst;
        r.count = b.count + 1'b1;
        return r;
    endfunction

endpackage

### hw/rtl/backslash_escape_decoder.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Stream decoder for backslash escapes, one text byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one raw text byte per item in tdata; tlast high
//   marks the end item of a text (its tdata is ignored).
//   Output stream m_axis: decoded bytes in tdata; tlast high marks the end
//   item of a text, which carries tdata = 0.
//   cfg_we/cfg_wdata write regex_mode (1 = only \0oo octal pairs decoded);
//   the user must write only while the block is idle; it is not enforced.
// Timing:
//   An accepted item is decoded in the cycle it arrives; its results appear
//   on m_axis from the next cycle, one per cycle while m_axis_tready is
//   high. Each item releases zero to four results, held in a four-entry
//   output buffer. Throughput is one item per cycle while items release at
//   most one byte each and m_axis_tready is high; an item releasing more
//   holds the input while the single output port drains the buffer.
//   s_axis_tready is high while the buffer is empty or sends its last entry.
// Reset: the scan state returns to idle, the buffer empties, regex_mode = 0.
// A stalled receiver holds the current byte; input stalls once the buffer
// cannot take the next burst.
// ----------------------------------------------------------------------------
`include "backslash_escape_decoder_defines.svh"

module backslash_escape_decoder
    import bed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_text
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // end_mark
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_wdata       // regex_mode
);

    scan_state_t             state_reg;
    scan_state_t             state_next;
    burst_t                  burst;
    logic                    regex_mode_reg;
    byte_t [MAX_RESULTS-1:0] buf_data_reg;
    logic  [MAX_RESULTS-1:0] buf_last_reg;
    logic  [CNT_W-1:0]       cnt_reg;
    logic  [IDX_W-1:0]       ptr_reg;
    logic                    in_fire;
    logic                    out_fire;

    // per-item decode
    bed_step u_step (
        .cur        (state_reg),
        .regex_mode (regex_mode_reg),
        .c          (s_axis_tdata),
        .eot        (s_axis_tlast),
        .nxt        (state_next),
        .burst      (burst)
    );

    // handshakes
    assign m_axis_tvalid = (cnt_reg != '0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = buf_data_reg[ptr_reg];
    assign m_axis_tlast  = buf_last_reg[ptr_reg];

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            regex_mode_reg <= 1'b0;
        else if (cfg_we)
            regex_mode_reg <= cfg_wdata;
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{phase: PH_IDLE, default: '0};
        else if (in_fire)
            state_reg <= state_next;
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end
        else if (in_fire)
        begin
            cnt_reg <= burst.count;
            ptr_reg <= '0;
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            ptr_reg <= ptr_reg + IDX_W'(1);
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_data_reg <= burst.data;
            buf_last_reg <= burst.last;
        end
    end

    // checks
    `BED_NEVER(a_cnt_range, clk, rst_n, cnt_reg > CNT_W'(MAX_RESULTS))
    `BED_ASSERT(a_accept_drained, clk, rst_n,
        in_fire |-> ((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_fire)))
    `BED_ASSERT(a_eot_idle, clk, rst_n,
        (in_fire && s_axis_tlast) |=> (state_reg.phase == PH_IDLE))
    `BED_ASSERT(a_last_is_final, clk, rst_n,
        (m_axis_tvalid && m_axis_tlast) |-> (cnt_reg == CNT_W'(1)))

endmodule

### hw/rtl/bed_step.sv
// ----------------------------------------------------------------------------
// bed_step
// Next-state and result logic for one input item of the escape decoder.
// ----------------------------------------------------------------------------
module bed_step
    import bed_pkg::*;
(
    input  scan_state_t cur,
    input  logic        regex_mode,
    input  byte_t       c,
    input  logic        eot,
    output scan_state_t nxt,
    output burst_t      burst
);

    logic [4:0]  hv;
    logic        hex_take;
    logic [2:0]  hex_lim;
    logic [2:0]  cnt_inc;
    logic [15:0] acc_new;
    logic        old_ok;
    logic        new_ok;
    logic        c_oct;
    logic        c_bslash;
    phase_t      plain_phase;
    byte_t       oct_char;

    // shared decode of the incoming byte
    always_comb
    begin
        hv          = hex_value(c);
        hex_lim     = cur.long_hex ? HEX_LONG_DIGITS : HEX_SHORT_DIGITS;
        hex_take    = hv[4] && (cur.digit_count < hex_lim);
        cnt_inc     = cur.digit_count + 3'd1;
        acc_new     = {cur.hex_accum[11:0], hv[3:0]};
        old_ok      = (cur.digit_count != 3'd0) && (cur.hex_accum != 16'd0)
                      && (cur.hex_accum[15:8] == 8'd0);
        new_ok      = (acc_new != 16'd0) && (acc_new[15:8] == 8'd0);
        c_oct       = is_octal(c);
        c_bslash    = (c == CH_BSLASH);
        plain_phase = c_bslash ? (regex_mode ? PH_R1 : PH_ESC) : PH_IDLE;
        oct_char    = {5'b00110, cur.first_octal};
    end

    // next state
    always_comb
    begin
        nxt = cur;
        if (eot)
        begin
            nxt = '{phase: PH_IDLE, default: '0};
        end
        else
        begin
            case (cur.phase)
                PH_ESC:
                begin
                    nxt.phase = PH_IDLE;
                    if (c == CH_LX || c == CH_LU)
                    begin
                        nxt.phase       = PH_HEX;
                        nxt.hex_accum   = 16'd0;
                        nxt.digit_count = 3'd0;
                        nxt.long_hex    = (c == CH_LU);
                    end
                end
                PH_HEX:
                begin
                    if (hex_take && cnt_inc < hex_lim)
                    begin
                        nxt.hex_accum   = acc_new;
                        nxt.digit_count = cnt_inc;
                    end
                    else
                    begin
                        nxt.hex_accum   = 16'd0;
                        nxt.digit_count = 3'd0;
                        nxt.long_hex    = 1'b0;
                        nxt.phase       = hex_take ? PH_IDLE : plain_phase;
                    end
                end
                PH_R1:
                    nxt.phase = (c == CH_ZERO) ? PH_R2 : plain_phase;
                PH_R2:
                begin
                    if (c_oct)
                    begin
                        nxt.first_octal = c[2:0];
                        nxt.phase       = PH_R3;
                    end
                    else
                    begin
                        nxt.phase = plain_phase;
                    end
                end
                PH_R3:
                begin
                    nxt.first_octal = 3'd0;
                    nxt.phase       = c_oct ? PH_IDLE : plain_phase;
                end
                default:
                    nxt.phase = plain_phase;
            endcase
        end
    end

    // released bytes
    always_comb
    begin
        burst = '0;
        if (eot)
        begin
            case (cur.phase)
                PH_HEX:
                    if (old_ok) burst = push(burst, cur.hex_accum[7:0], 1'b0);
                PH_R1:
                    burst = push(burst, CH_BSLASH, 1'b0);
                PH_R2:
                begin
                    burst = push(burst, CH_BSLASH, 1'b0);
                    burst = push(burst, CH_ZERO, 1'b0);
                end
                PH_R3:
                begin
                    burst = push(burst, CH_BSLASH, 1'b0);
                    burst = push(burst, CH_ZERO, 1'b0);
                    burst = push(burst, oct_char, 1'b0);
                end
                default:
                    ;
            endcase
            burst = push(burst, 8'h00, 1'b1);
        end
        else
        begin
            case (cur.phase)
                PH_ESC:
                begin
                    case (c)
                        CH_LA:   burst = push(burst, CC_BEL, 1'b0);
                        CH_LB:   burst = push(burst, CC_BS, 1'b0);
                        CH_LF:   burst = push(burst, CC_FF, 1'b0);
                        CH_LN:   burst = push(burst, CC_LF, 1'b0);
                        CH_LR:   burst = push(burst, CC_CR, 1'b0);
                        CH_LT:   burst = push(burst, CC_HT, 1'b0);
                        CH_LV:   burst = push(burst, CC_VT, 1'b0);
                        CH_LX:   ;
                        CH_LU:   ;
                        default: burst = push(burst, c, 1'b0);
                    endcase
                end
                PH_HEX:
                begin
                    if (hex_take)
                    begin
                        // last digit completes the escape
                        if (cnt_inc >= hex_lim && new_ok)
                            burst = push(burst, acc_new[7:0], 1'b0);
                    end
                    else
                    begin
                        // escape ends; this byte is taken as plain text or opens a new escape
                        if (old_ok)
                            burst = push(burst, cur.hex_accum[7:0], 1'b0);
                        if (!c_bslash)
                            burst = push(burst, c, 1'b0);
                    end
                end
                PH_R1:
                begin
                    if (c != CH_ZERO)
                    begin
                        burst = push(burst, CH_BSLASH, 1'b0);
                        if (!c_bslash) burst = push(burst, c, 1'b0);
                    end
                end
                PH_R2:
                begin
                    if (!c_oct)
                    begin
                        burst = push(burst, CH_BSLASH, 1'b0);
                        burst = push(burst, CH_ZERO, 1'b0);
                        if (!c_bslash) burst = push(burst, c, 1'b0);
                    end
                end
                PH_R3:
                begin
                    if (c_oct)
                    begin
                        burst = push(burst, {2'b00, cur.first_octal, c[2:0]}, 1'b0);
                    end
                    else
                    begin
                        burst = push(burst, CH_BSLASH, 1'b0);
                        burst = push(burst, CH_ZERO, 1'b0);
                        burst = push(burst, oct_char, 1'b0);
                        if (!c_bslash) burst = push(burst, c, 1'b0);
                    end
                end
                default:
                    if (!c_bslash) burst = push(burst, c, 1'b0);
            endcase
        end
    end

endmodule

### verif/backslash_escape_decoder_tb.sv
// ============================================================================
// backslash_escape_decoder_tb
// ----------------------------------------------------------------------------
// Self-checking bench for the backslash escape decoder. A short table of
// directed items covers the byte extremes, a control escape, hex escapes (a
// dropped zero value, the 255 maximum, digits cut off by end of text), a
// trailing backslash, a mode switch in the middle of an escape and the regex
// octal form. Random escape sequences follow under three stall profiles in
// both modes. Items are checked against typed-in results or a bench decoder.
// ============================================================================
module backslash_escape_decoder_tb
    import bed_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    CYCLE_LIMIT = 300000;
    localparam int    SEG_ITEMS   = 13;
    localparam byte_t CH_LZ       = 8'h7A;

    // one decoded output item
    typedef struct packed {
        byte_t value;
        logic  mark;
    } dec_t;

    // directed row: mode to run in, input item, and a typed-in result if known
    typedef struct packed {
        logic  mode;
        byte_t data;
        logic  eot;
        logic  known;
        byte_t kval;
        logic  kmark;
    } row_t;

    localparam int N_DIR = 30;
    localparam row_t DIR_ROWS [N_DIR] = '{
        '{1'b0, CH_UA,           1'b0, 1'b1, CH_UA,  1'b0},
        '{1'b0, 8'h00,           1'b0, 1'b1, 8'h00,  1'b0},
        '{1'b0, 8'hFF,           1'b0, 1'b1, 8'hFF,  1'b0},
        '{1'b0, CH_BSLASH,       1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, CH_LN,           1'b0, 1'b1, CC_LF,  1'b0},
        // \x00: zero value, dropped
        '{1'b0, CH_BSLASH,       1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, CH_LX,           1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, CH_ZERO,         1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, CH_ZERO,         1'b0, 1'b0, 8'h00,  1'b0},
        // \uFf cut short by a non-hex byte
        '{1'b0, CH_BSLASH,       1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, CH_LU,           1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, CH_UF,           1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, CH_LF,           1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, CH_LZ,           1'b0, 1'b0, 8'h00,  1'b0},
        // end of text inside hex digits
        '{1'b0, CH_BSLASH,       1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, CH_LX,           1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, CH_ZERO + 8'd4,  1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, 8'hA5,           1'b1, 1'b0, 8'h00,  1'b0},
        // trailing backslash dropped
        '{1'b0, CH_BSLASH,       1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b0, 8'h5A,           1'b1, 1'b1, 8'h00,  1'b1},
        // escape begun in plain mode, finished after switching to regex
        '{1'b0, CH_BSLASH,       1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b1, CH_BSLASH,       1'b0, 1'b0, 8'h00,  1'b0},
        // regex \077
        '{1'b1, CH_BSLASH,       1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b1, CH_ZERO,         1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b1, CH_SEVEN,        1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b1, CH_SEVEN,        1'b0, 1'b0, 8'h00,  1'b0},
        // regex partial match flushed by end of text
        '{1'b1, CH_BSLASH,       1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b1, CH_ZERO,         1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b1, CH_ZERO,         1'b0, 1'b0, 8'h00,  1'b0},
        '{1'b1, 8'h00,           1'b1, 1'b0, 8'h00,  1'b0}
    };

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  s_tvalid = 1'b0;
    byte_t s_tdata = 8'h00;
    logic  s_tlast = 1'b0;
    logic  m_tready = 1'b0;
    logic  cfg_we = 1'b0;
    logic  cfg_wdata = 1'b0;

    logic  s_axis_tready;
    logic  m_axis_tvalid;
    byte_t m_axis_tdata;
    logic  m_axis_tlast;

    // stall percentages for each side
    int tx_idle = 0;
    int rx_idle = 0;

    int errs = 0;
    int n_items = 0;
    int n_texts = 0;
    int n_checked = 0;
    int n_writes = 0;
    int cycles = 0;

    // decoded items still owed by the block, oldest first
    dec_t dec_q[$];
    dec_t burst[$];

    // decoder state mirror
    logic       mode = 1'b0;
    phase_t     ph = PH_IDLE;
    logic [15:0] acc = '0;
    logic [2:0] ndig = '0;
    logic       long_h = 1'b0;
    logic [2:0] oct1 = '0;

    backslash_escape_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Escape decoder mirror
    // ------------------------------------------------------------------------
    function automatic void put(byte_t v, logic m);
        burst.push_back('{v, m});
    endfunction

    // value of a hex digit character, -1 if none
    function automatic int nibble_of(byte_t c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c) - int'(CH_ZERO);
        if (c >= CH_UA && c <= CH_UF)
            return int'(c) - int'(CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF)
            return int'(c) - int'(CH_LA) + 10;
        return -1;
    endfunction

    function automatic logic octal_char(byte_t c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // hex escape done: keep only a value in 1..255
    function automatic void close_hex();
        if (ndig != 0 && acc != 0 && acc <= 16'd255)
            put(acc[7:0], 1'b0);
        ph = PH_IDLE;
        acc = '0;
        ndig = '0;
        long_h = 1'b0;
    endfunction

    // byte outside any escape; a backslash opens one in the current mode
    function automatic void take_plain(byte_t c);
        ph = PH_IDLE;
        if (c == CH_BSLASH)
            ph = mode ? PH_R1 : PH_ESC;
        else
            put(c, 1'b0);
    endfunction

    function automatic void flush_regex(int depth);
        put(CH_BSLASH, 1'b0);
        if (depth > 1)
            put(CH_ZERO, 1'b0);
        if (depth > 2)
            put(CH_ZERO + byte_t'(oct1), 1'b0);
    endfunction

    function automatic void decode_item(byte_t c, logic eot);
        int d;
        logic [2:0] lim;
        lim = long_h ? HEX_LONG_DIGITS : HEX_SHORT_DIGITS;
        if (eot)
        begin
            case (ph)
                PH_HEX:  close_hex();
                PH_R1:   flush_regex(1);
                PH_R2:   flush_regex(2);
                PH_R3:   flush_regex(3);
                default: ;
            endcase
            put(8'h00, 1'b1);
            ph = PH_IDLE;
            acc = '0;
            ndig = '0;
            long_h = 1'b0;
            oct1 = '0;
            return;
        end
        case (ph)
            PH_ESC:
            begin
                ph = PH_IDLE;
                case (c)
                    CH_LA:   put(CC_BEL, 1'b0);
                    CH_LB:   put(CC_BS, 1'b0);
                    CH_LF:   put(CC_FF, 1'b0);
                    CH_LN:   put(CC_LF, 1'b0);
                    CH_LR:   put(CC_CR, 1'b0);
                    CH_LT:   put(CC_HT, 1'b0);
                    CH_LV:   put(CC_VT, 1'b0);
                    CH_LX, CH_LU:
                    begin
                        ph = PH_HEX;
                        acc = '0;
                        ndig = '0;
                        long_h = (c == CH_LU);
                    end
                    default: put(c, 1'b0);
                endcase
            end
            PH_HEX:
            begin
                d = nibble_of(c);
                if (d >= 0 && ndig < lim)
                begin
                    acc = {acc[11:0], 4'(d)};
                    ndig = ndig + 3'd1;
                    if (ndig >= lim)
                        close_hex();
                end
                else
                begin
                    close_hex();
                    take_plain(c);
                end
            end
            PH_R1:
            begin
                if (c == CH_ZERO)
                    ph = PH_R2;
                else
                begin
                    flush_regex(1);
                    take_plain(c);
                end
            end
            PH_R2:
            begin
                if (octal_char(c))
                begin
                    oct1 = 3'(c - CH_ZERO);
                    ph = PH_R3;
                end
                else
                begin
                    flush_regex(2);
                    take_plain(c);
                end
            end
            PH_R3:
            begin
                if (octal_char(c))
                begin
                    put({2'b00, oct1, 3'(c - CH_ZERO)}, 1'b0);
                    ph = PH_IDLE;
                end
                else
                begin
                    flush_regex(3);
                    take_plain(c);
                end
                oct1 = '0;
            end
            default: take_plain(c);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // offer one item, with random gaps, and return at the accepting edge
    task automatic send_item(byte_t b, logic eot);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_items++;
        if (eot)
            n_texts++;
        burst.delete();
        decode_item(b, eot);
    endtask

    task automatic feed(byte_t b, logic eot);
        send_item(b, eot);
        foreach (burst[k])
            dec_q.push_back(burst[k]);
    endtask

    // stop offering until every owed item is out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (dec_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mode = m;
        n_writes++;
    endtask

    function automatic byte_t rand_hex_char();
        case ($urandom_range(0, 3))
            0:       return CH_ZERO;
            1:       return CH_ZERO + byte_t'($urandom_range(0, 9));
            2:       return CH_UA + byte_t'($urandom_range(0, 5));
            default: return CH_LA + byte_t'($urandom_range(0, 5));
        endcase
    endfunction

    // mostly octal digits, sometimes the two just past them, sometimes noise
    function automatic byte_t rand_octal_char();
        int k;
        k = $urandom_range(0, 99);
        if (k < 80)
            return CH_ZERO + byte_t'($urandom_range(0, 7));
        if (k < 90)
            return CH_ZERO + byte_t'($urandom_range(8, 9));
        return byte_t'($urandom_range(0, 255));
    endfunction

    // one random sequence: mostly escapes with random content, some noise
    task automatic random_seq();
        int k;
        int nd;
        k = $urandom_range(0, 99);
        if (k < 12)
            feed(byte_t'($urandom_range(0, 255)), 1'b0);
        else if (k < 30)
        begin
            feed(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 8))
                0:       feed(CH_LA, 1'b0);
                1:       feed(CH_LB, 1'b0);
                2:       feed(CH_LF, 1'b0);
                3:       feed(CH_LN, 1'b0);
                4:       feed(CH_LR, 1'b0);
                5:       feed(CH_LT, 1'b0);
                6:       feed(CH_LV, 1'b0);
                7:       feed(CH_BSLASH, 1'b0);
                default: feed(byte_t'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        else if (k < 52)
        begin
            feed(CH_BSLASH, 1'b0);
            feed($urandom_range(0, 1) ? CH_LU : CH_LX, 1'b0);
            nd = $urandom_range(0, 5);
            repeat (nd) feed(rand_hex_char(), 1'b0);
            if ($urandom_range(0, 1))
                feed(byte_t'($urandom_range(0, 255)), 1'b0);
        end
        else if (k < 74)
        begin
            feed(CH_BSLASH, 1'b0);
            feed(($urandom_range(0, 9) != 0) ? CH_ZERO : byte_t'($urandom_range(0, 255)),
                 1'b0);
            feed(rand_octal_char(), 1'b0);
            feed(rand_octal_char(), 1'b0);
        end
        else if (k < 82)
        begin
            feed(CH_BSLASH, 1'b0);
            feed(byte_t'($urandom_range(0, 255)), 1'b1);
        end
        else if (k < 90)
            feed(byte_t'($urandom_range(0, 255)), 1'b1);
        else
            feed(byte_t'($urandom_range(0, 255)), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random back-pressure
    // ------------------------------------------------------------------------
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle);

    // compare each accepted output item with the oldest owed one
    always @(posedge clk)
    begin
        dec_t want;
        if (rst_n && m_axis_tvalid && m_tready)
        begin
            if (dec_q.size() == 0)
            begin
                $error("unexpected item: out_byte %02h end_mark %0b",
                       m_axis_tdata, m_axis_tlast);
                errs++;
            end
            else
            begin
                want = dec_q.pop_front();
                n_checked++;
                if (m_axis_tdata !== want.value)
                begin
                    $error("out_byte mismatch: expected %02h, actual %02h",
                           want.value, m_axis_tdata);
                    errs++;
                end
                if (m_axis_tlast !== want.mark)
                begin
                    $error("end_mark mismatch: expected %0b, actual %0b",
                           want.mark, m_axis_tlast);
                    errs++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items still owed", cycles, dec_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int seg_start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIR; i++)
        begin
            if (DIR_ROWS[i].mode != mode)
            begin
                drain();
                write_mode(DIR_ROWS[i].mode);
            end
            send_item(DIR_ROWS[i].data, DIR_ROWS[i].eot);
            if (DIR_ROWS[i].known)
                dec_q.push_back('{DIR_ROWS[i].kval, DIR_ROWS[i].kmark});
            else
                foreach (burst[k])
                    dec_q.push_back(burst[k]);
        end

        // random texts: three stall profiles, each in both modes
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:       begin tx_idle = 26; rx_idle = 58; end
                1:       begin tx_idle = 58; rx_idle = 26; end
                default: begin tx_idle = 0;  rx_idle = 0;  end
            endcase
            for (int m = 0; m < 2; m++)
            begin
                drain();
                write_mode(m[0]);
                seg_start = n_items;
                while (n_items - seg_start < SEG_ITEMS)
                    random_seq();
                feed(byte_t'($urandom_range(0, 255)), 1'b1);
            end
        end

        drain();
        repeat (10) @(posedge clk);

        $display("Run covered %0d input items over %0d texts and %0d mode writes;",
                 n_items, n_texts, n_writes);
        $display("%0d decoded items checked under three stall profiles, %0d errors.",
                 n_checked, errs);
        if (errs == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/bed_pkg.sv
hw/rtl/bed_step.sv
hw/rtl/backslash_escape_decoder.sv
verif/backslash_escape_decoder_tb.sv
